@@ design/qvu_pkg.sv @@
// Shared constants, types and helper functions of the Q-value update engine.
package qvu_pkg;

	// Table geometry.
	localparam int NUM_STATES_MAX  = 32;
	localparam int NUM_ACTIONS_MAX = 8;
	localparam int STATE_W         = $clog2(NUM_STATES_MAX);
	localparam int ACT_W           = $clog2(NUM_ACTIONS_MAX);
	localparam int TABLE_DEPTH     = NUM_STATES_MAX * NUM_ACTIONS_MAX;
	localparam int ADDR_W          = $clog2(TABLE_DEPTH);

	// Fixed field widths of the stream words.
	localparam int CUR_STATE_W    = 5;
	localparam int TAKEN_ACTION_W = 3;
	localparam int NEXT_STATE_W   = 5;
	localparam int GREEDY_W       = 3;
	localparam int Q_W            = 16;
	localparam int RATE_W         = 16;
	localparam int FRAC_W         = 16;

	// Stream word layouts, lowest field first.
	localparam int IN_CS_LO   = 0;
	localparam int IN_TA_LO   = IN_CS_LO + CUR_STATE_W;
	localparam int IN_RW_LO   = IN_TA_LO + TAKEN_ACTION_W;
	localparam int IN_NS_LO   = IN_RW_LO + Q_W;
	localparam int IN_USED_W  = IN_NS_LO + NEXT_STATE_W;
	localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

	localparam int OUT_NQ_LO   = 0;
	localparam int OUT_GA_LO   = OUT_NQ_LO + Q_W;
	localparam int OUT_SV_LO   = OUT_GA_LO + GREEDY_W;
	localparam int OUT_USED_W  = OUT_SV_LO + Q_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 1;

	// Arithmetic widths: target and difference in Q.24, product and sum in Q.40.
	localparam int DIFF_W = 34;
	localparam int PROD_W = DIFF_W + RATE_W + 1;
	localparam int FULL_W = PROD_W + 1;
	localparam int RES_W  = FULL_W - 2 * FRAC_W;

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT  = 1'd1;
	localparam logic [RATE_W-1:0]    STEP_SIZE_RST = 16'd6554;
	localparam logic [RATE_W-1:0]    DISCOUNT_RST  = 16'd58982;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_NEXT,
		S_READ_Q,
		S_MUL_G,
		S_ADD_T,
		S_MUL_A,
		S_ADD_F,
		S_WRITE,
		S_SCAN_CUR,
		S_LAST_CMP,
		S_DONE
	} state_t;

	// Control word from the sequencer to the datapath.
	typedef struct packed {
		logic             capture;
		logic             rd_en;
		logic             rd_cur;
		logic             rd_taken;
		logic [ACT_W-1:0] rd_col;
		logic             cmp_en;
		logic             cmp_first;
		logic             mul_en;
		logic             mul_alpha;
		logic             diff_en;
		logic             fin_en;
		logic             wr_en;
	} ctrl_t;

	// Out-of-range state indexes saturate to the last row.
	function automatic logic [STATE_W-1:0] clamp_state(input logic [CUR_STATE_W-1:0] v);
		logic [STATE_W-1:0] r;
		if (32'(v) >= NUM_STATES_MAX) begin
			r = STATE_W'(NUM_STATES_MAX - 1);
		end else begin
			r = STATE_W'(v);
		end
		return r;
	endfunction

	// Out-of-range action indexes saturate to the last column.
	function automatic logic [ACT_W-1:0] clamp_action(input logic [TAKEN_ACTION_W-1:0] v);
		logic [ACT_W-1:0] r;
		if (32'(v) >= NUM_ACTIONS_MAX) begin
			r = ACT_W'(NUM_ACTIONS_MAX - 1);
		end else begin
			r = ACT_W'(v);
		end
		return r;
	endfunction

endpackage

@@ design/qvu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module qvu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/qvu_table.sv @@
// Q table: RAM plus per-entry valid bits so that unwritten entries read as zero.
module qvu_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [qvu_pkg::ADDR_W-1:0]  rd_addr,
	output logic [qvu_pkg::Q_W-1:0]     rd_data,
	input  logic                        wr_en,
	input  logic [qvu_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [qvu_pkg::Q_W-1:0]     wr_data
);

	logic [qvu_pkg::TABLE_DEPTH-1:0] valid_q;
	logic                            vld_s1;
	logic [qvu_pkg::Q_W-1:0]         ram_data;

	qvu_ram #(
		.WIDTH(qvu_pkg::Q_W),
		.DEPTH(qvu_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_data)
	);

	// Valid bits: reset clears the whole table at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// The valid bit follows the read data through the read register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rd_en) begin
			vld_s1 <= valid_q[rd_addr];
		end
	end

	assign rd_data = vld_s1 ? ram_data : '0;

	// A read never targets the entry being written in the same cycle.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("table read and write hit the same entry");

endmodule

@@ design/qvu_alu.sv @@
// Datapath: captured transition, running row maximum, shared multiplier and adders.
module qvu_alu (
	input  logic                            clk,
	input  logic                            arst_n,
	input  qvu_pkg::ctrl_t                  ctrl,
	input  logic [qvu_pkg::IN_TDATA_W-1:0]  in_word,
	input  logic [qvu_pkg::RATE_W-1:0]      step_size,
	input  logic [qvu_pkg::RATE_W-1:0]      discount,
	input  logic [qvu_pkg::Q_W-1:0]         rd_data,
	output logic [qvu_pkg::ADDR_W-1:0]      rd_addr,
	output logic [qvu_pkg::ADDR_W-1:0]      wr_addr,
	output logic [qvu_pkg::Q_W-1:0]         wr_data,
	output logic [qvu_pkg::Q_W-1:0]         new_q,
	output logic                            saturated,
	output logic [qvu_pkg::GREEDY_W-1:0]    greedy_action,
	output logic [qvu_pkg::Q_W-1:0]         state_value
);

	// Captured transition.
	logic [qvu_pkg::STATE_W-1:0] s_q;
	logic [qvu_pkg::STATE_W-1:0] ns_q;
	logic [qvu_pkg::ACT_W-1:0]   a_q;
	logic signed [qvu_pkg::Q_W-1:0] reward_q;

	// Read-side pipeline and running maximum.
	logic                           cmp_en_s1;
	logic                           cmp_first_s1;
	logic                           ld_q_s1;
	logic [qvu_pkg::ACT_W-1:0]      cmp_col_s1;
	logic signed [qvu_pkg::Q_W-1:0] best_val_q;
	logic [qvu_pkg::ACT_W-1:0]      best_idx_q;
	logic signed [qvu_pkg::Q_W-1:0] q_q;

	// Arithmetic.
	logic signed [qvu_pkg::RATE_W:0]     op_a;
	logic signed [qvu_pkg::DIFF_W-1:0]   op_b;
	logic signed [qvu_pkg::PROD_W-1:0]   prod_c;
	logic signed [qvu_pkg::PROD_W-1:0]   prod_q;
	logic signed [qvu_pkg::DIFF_W-1:0]   q_ext;
	logic signed [qvu_pkg::DIFF_W-1:0]   rew_ext;
	logic signed [qvu_pkg::DIFF_W-1:0]   gprod;
	logic signed [qvu_pkg::DIFF_W-1:0]   diff_c;
	logic signed [qvu_pkg::DIFF_W-1:0]   diff_q;
	logic signed [qvu_pkg::FULL_W-1:0]   q_full;
	logic signed [qvu_pkg::FULL_W-1:0]   prod_full;
	logic signed [qvu_pkg::FULL_W-1:0]   sum_c;
	logic signed [qvu_pkg::RES_W-1:0]    res_c;
	logic                                ovf_c;
	logic [qvu_pkg::Q_W-1:0]             clamp_c;
	logic [qvu_pkg::Q_W-1:0]             new_q_q;
	logic                                sat_q;
	logic [qvu_pkg::STATE_W-1:0]         row_c;
	logic [qvu_pkg::ACT_W-1:0]           col_c;

	// Capture the accepted word; indexes saturate to the table bounds.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			s_q      <= qvu_pkg::clamp_state(
				in_word[qvu_pkg::IN_CS_LO +: qvu_pkg::CUR_STATE_W]);
			a_q      <= qvu_pkg::clamp_action(
				in_word[qvu_pkg::IN_TA_LO +: qvu_pkg::TAKEN_ACTION_W]);
			reward_q <= $signed(in_word[qvu_pkg::IN_RW_LO +: qvu_pkg::Q_W]);
			ns_q     <= qvu_pkg::clamp_state(
				in_word[qvu_pkg::IN_NS_LO +: qvu_pkg::NEXT_STATE_W]);
		end
	end

	// Table addressing.
	always_comb begin
		row_c   = ctrl.rd_cur ? s_q : ns_q;
		col_c   = ctrl.rd_taken ? a_q : ctrl.rd_col;
		rd_addr = qvu_pkg::ADDR_W'(row_c) * qvu_pkg::ADDR_W'(qvu_pkg::NUM_ACTIONS_MAX)
			+ qvu_pkg::ADDR_W'(col_c);
		wr_addr = qvu_pkg::ADDR_W'(s_q) * qvu_pkg::ADDR_W'(qvu_pkg::NUM_ACTIONS_MAX)
			+ qvu_pkg::ADDR_W'(a_q);
	end

	assign wr_data = new_q_q;

	// Control flags that line up with the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_en_s1    <= 1'b0;
			cmp_first_s1 <= 1'b0;
			ld_q_s1      <= 1'b0;
		end else begin
			cmp_en_s1    <= ctrl.cmp_en;
			cmp_first_s1 <= ctrl.cmp_first;
			ld_q_s1      <= ctrl.rd_taken;
		end
	end

	always_ff @(posedge clk) begin
		cmp_col_s1 <= ctrl.rd_col;
	end

	// Running maximum; a strict compare keeps the lowest index on ties.
	always_ff @(posedge clk) begin
		if (cmp_en_s1 && (cmp_first_s1 || ($signed(rd_data) > best_val_q))) begin
			best_val_q <= $signed(rd_data);
			best_idx_q <= cmp_col_s1;
		end
		if (ld_q_s1) begin
			q_q <= $signed(rd_data);
		end
	end

	// Shared multiplier: gamma times maxQ first, then alpha times the difference.
	always_comb begin
		op_a = $signed({1'b0, ctrl.mul_alpha ? step_size : discount});
		op_b = ctrl.mul_alpha ? diff_q
			: {{(qvu_pkg::DIFF_W - qvu_pkg::Q_W){best_val_q[qvu_pkg::Q_W-1]}}, best_val_q};
		prod_c = op_a * op_b;
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod_c;
		end
	end

	// Difference Q*2^16 - (reward*2^16 + gamma*maxQ).
	always_comb begin
		q_ext   = {{(qvu_pkg::DIFF_W - qvu_pkg::Q_W){q_q[qvu_pkg::Q_W-1]}}, q_q};
		rew_ext = {{(qvu_pkg::DIFF_W - qvu_pkg::Q_W){reward_q[qvu_pkg::Q_W-1]}}, reward_q};
		gprod   = $signed(prod_q[qvu_pkg::DIFF_W-1:0]);
		diff_c  = (q_ext <<< qvu_pkg::FRAC_W) - (rew_ext <<< qvu_pkg::FRAC_W) - gprod;
	end

	always_ff @(posedge clk) begin
		if (ctrl.diff_en) begin
			diff_q <= diff_c;
		end
	end

	// New value Q*2^32 - alpha*diff, rounded half up to Q8.8 and clamped.
	always_comb begin
		q_full    = {{(qvu_pkg::FULL_W - qvu_pkg::Q_W){q_q[qvu_pkg::Q_W-1]}}, q_q};
		prod_full = {{(qvu_pkg::FULL_W - qvu_pkg::PROD_W){prod_q[qvu_pkg::PROD_W-1]}}, prod_q};
		sum_c     = (q_full <<< (2 * qvu_pkg::FRAC_W)) - prod_full
			+ (qvu_pkg::FULL_W'(1) <<< (2 * qvu_pkg::FRAC_W - 1));
		res_c     = $signed(sum_c[qvu_pkg::FULL_W-1:2*qvu_pkg::FRAC_W]);
		ovf_c     = (res_c[qvu_pkg::RES_W-1:qvu_pkg::Q_W-1] != '0)
			&& (res_c[qvu_pkg::RES_W-1:qvu_pkg::Q_W-1] != '1);
		if (!ovf_c) begin
			clamp_c = res_c[qvu_pkg::Q_W-1:0];
		end else if (res_c[qvu_pkg::RES_W-1]) begin
			clamp_c = {1'b1, {(qvu_pkg::Q_W-1){1'b0}}};
		end else begin
			clamp_c = {1'b0, {(qvu_pkg::Q_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin_en) begin
			new_q_q <= clamp_c;
			sat_q   <= ovf_c;
		end
	end

	assign new_q         = new_q_q;
	assign saturated     = sat_q;
	assign greedy_action = qvu_pkg::GREEDY_W'(best_idx_q);
	assign state_value   = best_val_q;

endmodule

@@ design/qvu_ctrl.sv @@
// Sequencer: steps one transition through scans, multiplies, write-back and output.
module qvu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_free,
	output logic           in_ready,
	output logic           out_load,
	output qvu_pkg::ctrl_t ctrl
);

	localparam logic [qvu_pkg::ACT_W-1:0] LAST_COL = qvu_pkg::ACT_W'(qvu_pkg::NUM_ACTIONS_MAX - 1);

	qvu_pkg::state_t           state_q;
	qvu_pkg::state_t           state_d;
	logic [qvu_pkg::ACT_W-1:0] cnt_q;
	logic [qvu_pkg::ACT_W-1:0] cnt_d;

	// State and column counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qvu_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and control word.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ctrl     = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			qvu_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.capture = 1'b1;
					cnt_d        = '0;
					state_d      = qvu_pkg::S_SCAN_NEXT;
				end
			end
			qvu_pkg::S_SCAN_NEXT: begin
				ctrl.rd_en     = 1'b1;
				ctrl.rd_col    = cnt_q;
				ctrl.cmp_en    = 1'b1;
				ctrl.cmp_first = (cnt_q == '0);
				if (cnt_q == LAST_COL) begin
					cnt_d   = '0;
					state_d = qvu_pkg::S_READ_Q;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			qvu_pkg::S_READ_Q: begin
				ctrl.rd_en    = 1'b1;
				ctrl.rd_cur   = 1'b1;
				ctrl.rd_taken = 1'b1;
				state_d       = qvu_pkg::S_MUL_G;
			end
			qvu_pkg::S_MUL_G: begin
				ctrl.mul_en = 1'b1;
				state_d     = qvu_pkg::S_ADD_T;
			end
			qvu_pkg::S_ADD_T: begin
				ctrl.diff_en = 1'b1;
				state_d      = qvu_pkg::S_MUL_A;
			end
			qvu_pkg::S_MUL_A: begin
				ctrl.mul_en    = 1'b1;
				ctrl.mul_alpha = 1'b1;
				state_d        = qvu_pkg::S_ADD_F;
			end
			qvu_pkg::S_ADD_F: begin
				ctrl.fin_en = 1'b1;
				state_d     = qvu_pkg::S_WRITE;
			end
			qvu_pkg::S_WRITE: begin
				ctrl.wr_en = 1'b1;
				cnt_d      = '0;
				state_d    = qvu_pkg::S_SCAN_CUR;
			end
			qvu_pkg::S_SCAN_CUR: begin
				ctrl.rd_en     = 1'b1;
				ctrl.rd_cur    = 1'b1;
				ctrl.rd_col    = cnt_q;
				ctrl.cmp_en    = 1'b1;
				ctrl.cmp_first = (cnt_q == '0);
				if (cnt_q == LAST_COL) begin
					cnt_d   = '0;
					state_d = qvu_pkg::S_LAST_CMP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			qvu_pkg::S_LAST_CMP: begin
				state_d = qvu_pkg::S_DONE;
			end
			qvu_pkg::S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = qvu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = qvu_pkg::S_IDLE;
			end
		endcase
	end

	// The current-row scan always starts from column zero after the write-back.
	a_scan_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qvu_pkg::S_WRITE) |=> (state_q == qvu_pkg::S_SCAN_CUR && cnt_q == '0))
		else $error("current-row scan did not start at column zero");

	// A result is only loaded into a free output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded while output register busy");

endmodule

@@ design/tabular_q_value_update_top.sv @@
// An accepted word steps through the next-row scan, Q read, gamma multiply, difference,
// alpha multiply, rounding, write-back, current-row scan and output load; a new one is
// taken only after that: two row scans share one read port, one multiplier is used twice.
// Result waits in an output register; a new transition is taken while it waits.
// Reset (arst_n low) clears the whole Q table to zero at once through per-entry valid
// bits and loads step size = 6554, discount = 58982; no clearing pass is needed.
module tabular_q_value_update_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [qvu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qvu_pkg::RATE_W-1:0]        cfg_data,
	// Transition stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: cur_state[4:0], taken_action[7:5], reward[23:8], next_state[28:24], zero pad
	input  logic [qvu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// Result stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: new_q[15:0], greedy_action[18:16], state_value[34:19], zero pad
	output logic [qvu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// tuser: saturated[0]
	output logic [qvu_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

	logic [qvu_pkg::RATE_W-1:0]     step_size_q;
	logic [qvu_pkg::RATE_W-1:0]     discount_q;
	qvu_pkg::ctrl_t                 ctrl;
	logic                           out_load;
	logic                           out_free;
	logic [qvu_pkg::ADDR_W-1:0]     rd_addr;
	logic [qvu_pkg::ADDR_W-1:0]     wr_addr;
	logic [qvu_pkg::Q_W-1:0]        wr_data;
	logic [qvu_pkg::Q_W-1:0]        rd_data;
	logic [qvu_pkg::Q_W-1:0]        new_q;
	logic                           saturated;
	logic [qvu_pkg::GREEDY_W-1:0]   greedy_action;
	logic [qvu_pkg::Q_W-1:0]        state_value;
	logic                           m_valid_q;
	logic [qvu_pkg::OUT_TDATA_W-1:0] m_data_q;
	logic [qvu_pkg::OUT_TUSER_W-1:0] m_user_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= qvu_pkg::STEP_SIZE_RST;
			discount_q  <= qvu_pkg::DISCOUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qvu_pkg::CFG_STEP_SIZE: step_size_q <= cfg_data;
				qvu_pkg::CFG_DISCOUNT:  discount_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	qvu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.out_free(out_free),
		.in_ready(s_axis_tready),
		.out_load(out_load),
		.ctrl    (ctrl)
	);

	qvu_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (ctrl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (ctrl.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	qvu_alu u_alu (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.in_word      (s_axis_tdata),
		.step_size    (step_size_q),
		.discount     (discount_q),
		.rd_data      (rd_data),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.new_q        (new_q),
		.saturated    (saturated),
		.greedy_action(greedy_action),
		.state_value  (state_value)
	);

	// Output register: holds one result word until the consumer takes it.
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= qvu_pkg::OUT_TDATA_W'({state_value, greedy_action, new_q});
			m_user_q <= qvu_pkg::OUT_TUSER_W'(saturated);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// One transition at a time: no second word is taken right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a transition is in progress");

	// A loaded result is presented on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid)
		else $error("loaded result not presented");

endmodule

@@ test/tb_tabular_q_value_update_top.sv @@
// Self-checking testbench for the Q-value update engine: directed and random transitions.
`timescale 1ns / 100ps

module tb_tabular_q_value_update_top;
	import qvu_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 30;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 300;

	// Expected contents of one result word.
	typedef struct packed {
		logic signed [Q_W-1:0] new_q;
		logic [GREEDY_W-1:0]   greedy;
		logic signed [Q_W-1:0] best_q;
		logic                  clamped;
	} q_update_t;

	// Shadow Q table with the update rule, plus the queue of updates still owed.
	class q_update_model;
		logic signed [Q_W-1:0] q_tab [TABLE_DEPTH];
		longint                alpha;
		longint                gamma;
		q_update_t             pending [$];
		int                    mismatches;

		function new();
			foreach (q_tab[i]) q_tab[i] = '0;
			alpha = longint'(STEP_SIZE_RST);
			gamma = longint'(DISCOUNT_RST);
			mismatches = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] v);
			if (idx == CFG_STEP_SIZE) begin
				alpha = longint'(v);
			end else if (idx == CFG_DISCOUNT) begin
				gamma = longint'(v);
			end
		endfunction

		// Index of the first maximum in a row; its value goes to val.
		function int row_best(int row, output logic signed [Q_W-1:0] val);
			int                    best;
			logic signed [Q_W-1:0] bv;
			best = 0;
			bv = q_tab[row * NUM_ACTIONS_MAX];
			for (int c = 1; c < NUM_ACTIONS_MAX; c++) begin
				if (q_tab[row * NUM_ACTIONS_MAX + c] > bv) begin
					bv = q_tab[row * NUM_ACTIONS_MAX + c];
					best = c;
				end
			end
			val = bv;
			return best;
		endfunction

		// Apply one accepted transition and queue the result it must produce.
		function void absorb_transition(logic [IN_TDATA_W-1:0] w);
			int                    s;
			int                    act;
			int                    ns;
			int                    slot;
			longint                rw;
			longint                qv;
			longint                tgt;
			longint                diff;
			longint                full;
			longint                res;
			logic signed [Q_W-1:0] next_max;
			logic signed [Q_W-1:0] row_max;
			q_update_t             r;
			s = int'(w[IN_CS_LO +: CUR_STATE_W]);
			act = int'(w[IN_TA_LO +: TAKEN_ACTION_W]);
			ns = int'(w[IN_NS_LO +: NEXT_STATE_W]);
			if (s >= NUM_STATES_MAX) s = NUM_STATES_MAX - 1;
			if (ns >= NUM_STATES_MAX) ns = NUM_STATES_MAX - 1;
			if (act >= NUM_ACTIONS_MAX) act = NUM_ACTIONS_MAX - 1;
			rw = longint'($signed(w[IN_RW_LO +: Q_W]));

			// The next-state maximum is read before this update lands.
			void'(row_best(ns, next_max));
			slot = s * NUM_ACTIONS_MAX + act;
			qv = longint'(q_tab[slot]);
			tgt = rw * 65536 + gamma * longint'(next_max);
			diff = qv * 65536 - tgt;
			full = qv * (longint'(1) <<< 32) - alpha * diff;
			res = (full + (longint'(1) <<< 31)) >>> 32;

			r.clamped = 1'b0;
			if (res > 32767) begin
				res = 32767;
				r.clamped = 1'b1;
			end else if (res < -32768) begin
				res = -32768;
				r.clamped = 1'b1;
			end
			q_tab[slot] = Q_W'(res);
			r.new_q = Q_W'(res);
			r.greedy = GREEDY_W'(row_best(s, row_max));
			r.best_q = row_max;
			pending = {pending, r};
		endfunction

		// Compare one accepted result word with the oldest owed update.
		function void check_update(logic [OUT_TDATA_W-1:0] w, logic [OUT_TUSER_W-1:0] u);
			q_update_t             e;
			logic signed [Q_W-1:0] nq;
			logic signed [Q_W-1:0] sv;
			logic [GREEDY_W-1:0]   ga;
			if (pending.size() == 0) begin
				$error("result word arrived with no transition pending");
				mismatches++;
			end else begin
				e = pending.pop_front();
				nq = w[OUT_NQ_LO +: Q_W];
				ga = w[OUT_GA_LO +: GREEDY_W];
				sv = w[OUT_SV_LO +: Q_W];
				if (nq !== e.new_q) begin
					$error("new_q: expected %0d, got %0d", e.new_q, nq);
					mismatches++;
				end
				if (ga !== e.greedy) begin
					$error("greedy_action: expected %0d, got %0d", e.greedy, ga);
					mismatches++;
				end
				if (sv !== e.best_q) begin
					$error("state_value: expected %0d, got %0d", e.best_q, sv);
					mismatches++;
				end
				if (u[0] !== e.clamped) begin
					$error("saturated: expected %0d, got %0d", e.clamped, u[0]);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [RATE_W-1:0]       cfg_data = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic [OUT_TUSER_W-1:0]  m_axis_tuser;

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	q_update_model qmodel;

	tabular_q_value_update_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// Result side: random stalls, plus one long hold-off when requested.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Handshake monitor: feeds the model, checks results and runs the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				qmodel.absorb_transition(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				qmodel.check_update(m_axis_tdata, m_axis_tuser);
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Write both rate registers; only called while the block is idle.
	task automatic set_rates(logic [RATE_W-1:0] alpha, logic [RATE_W-1:0] gamma);
		cfg_we <= 1'b1;
		cfg_index <= CFG_STEP_SIZE;
		cfg_data <= alpha;
		@(posedge clk);
		cfg_index <= CFG_DISCOUNT;
		cfg_data <= gamma;
		@(posedge clk);
		cfg_we <= 1'b0;
		qmodel.set_register(CFG_STEP_SIZE, alpha);
		qmodel.set_register(CFG_DISCOUNT, gamma);
	endtask

	// Wait until every owed result has come back, then let the pipeline settle.
	task automatic wait_drained();
		@(posedge clk);
		while (qmodel.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one transition word and return at the edge that accepts it.
	task automatic send_transition(int cs, int ta, int rw, int ns);
		int                    gap;
		logic [IN_TDATA_W-1:0] w;
		gap = 0;
		while ($urandom_range(0, 99) < sender_idle_pct) gap++;
		if (sender_idle_pct != 0 && $urandom_range(0, 7) == 0) begin
			gap += $urandom_range(1, 30);
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w = '0;
		w[IN_CS_LO +: CUR_STATE_W] = cs[CUR_STATE_W-1:0];
		w[IN_TA_LO +: TAKEN_ACTION_W] = ta[TAKEN_ACTION_W-1:0];
		w[IN_RW_LO +: Q_W] = rw[Q_W-1:0];
		w[IN_NS_LO +: NEXT_STATE_W] = ns[NEXT_STATE_W-1:0];
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Mostly episode-like walks over a few hot states, some fully random jumps.
	task automatic random_transition(inout int walk);
		int cs;
		int ns;
		int rw;
		int pick;
		if ($urandom_range(0, 9) < 6) begin
			cs = walk;
			ns = $urandom_range(0, 5);
		end else begin
			cs = $urandom_range(0, 31);
			ns = $urandom_range(0, 31);
		end
		if ($urandom_range(0, 7) == 0) ns = cs;
		walk = ns;
		pick = $urandom_range(0, 19);
		if (pick < 5) begin
			rw = int'($urandom_range(0, 65535)) - 32768;
		end else if (pick < 15) begin
			rw = int'($urandom_range(0, 1024)) - 512;
		end else if (pick < 18) begin
			rw = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
		end else begin
			rw = 0;
		end
		send_transition(cs, $urandom_range(0, 7), rw, ns);
	endtask

	initial begin
		int walk;
		walk = 0;
		qmodel = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full rates: drive rows to both saturation limits.
		set_rates(16'hFFFF, 16'hFFFF);
		repeat (3) send_transition(0, 0, 32767, 0);
		repeat (3) send_transition(1, 7, -32768, 1);
		send_transition(2, 3, 256, 0);
		// Next state equal to current state uses the row before the update.
		send_transition(2, 3, -256, 2);
		// Ties in the greedy scan resolve to the lowest action.
		send_transition(3, 5, 0, 3);
		send_transition(3, 5, 256, 4);
		send_transition(3, 2, 256, 4);
		send_transition(31, 7, 32767, 30);
		send_transition(31, 0, -1, 31);
		s_axis_tvalid <= 1'b0;

		// Zero step size leaves the table untouched.
		wait_drained();
		set_rates(16'h0000, 16'hFFFF);
		send_transition(0, 0, -32768, 31);
		send_transition(5, 4, 12345, 0);
		s_axis_tvalid <= 1'b0;

		// Zero discount: the update sees only the reward.
		wait_drained();
		set_rates(16'hFFFF, 16'h0000);
		send_transition(0, 0, -32768, 0);
		send_transition(4, 1, -32768, 0);
		send_transition(4, 6, -32767, 4);
		s_axis_tvalid <= 1'b0;

		// Random phases, each with its own rates and idling pattern.
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (p)
				0: set_rates(STEP_SIZE_RST, DISCOUNT_RST);
				1: set_rates(16'hFFFF, 16'hFFFF);
				2: set_rates(16'h0000, 16'h0000);
				3: set_rates(16'hFFFF, 16'h0000);
				4: set_rates(16'h0000, 16'hFFFF);
				default: set_rates(RATE_W'($urandom_range(0, 65535)),
					RATE_W'($urandom_range(0, 65535)));
			endcase
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					sender_idle_pct = 70;
					stall_pct <= 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct <= 70;
				end
				default: begin
					sender_idle_pct = 23;
					stall_pct <= 23;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Long result-side hold while words keep coming, to back up the input.
				if (p == 0 && i == 40) hold_req <= hold_req + 1;
				random_transition(walk);
			end
			s_axis_tvalid <= 1'b0;
		end

		wait_drained();
		if (qmodel.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
